// ===== rtl/core/pfr_pkg.sv =====
// Package for the prebuffered frame ring: sizes, request and status codes,
// item structs and the command bundle between controller and datapath.
// No dependencies.
package pfr_pkg;

  localparam int DEPTH      = 64;
  localparam int MAX_LENGTH = 65535;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CFG_W      = 7;
  localparam int ID_W       = 32;
  localparam int USER_W     = 32;
  localparam int LEN_W      = 16;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_GET     = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_STOP    = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_STOPPED  = 3'd1,
    ST_PREBUF   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ID_W-1:0]   stream_id;
    logic [USER_W-1:0] user_data;
    logic [LEN_W-1:0]  frame_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ID_W-1:0]   out_stream_id;
    logic [USER_W-1:0] out_user_data;
    logic [LEN_W-1:0]  out_length;
    logic [CFG_W-1:0]  fill_level;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [USER_W-1:0] user;
    logic [LEN_W-1:0]  len;
  } desc_t;

  typedef struct packed {
    logic [CFG_W-1:0] ring_size;
    logic [CFG_W-1:0] prebuffer_count;
  } cfg_t;

  typedef struct packed {
    logic exec;
    logic emit;
  } ctl_cmd_t;

endpackage

// ===== rtl/core/pfr_regs.sv =====
// Configuration registers of the frame ring behind an APB-style port.
// Depends on pfr_pkg.
module pfr_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pfr_pkg::PADDR_W-1:0]  paddr,
  input  logic [pfr_pkg::PDATA_W-1:0]  pwdata,
  output logic [pfr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output pfr_pkg::cfg_t                cfg
);
  import pfr_pkg::*;

  localparam logic REG_RING_SIZE = 1'b0;
  localparam logic REG_PREBUF    = 1'b1;

  logic [CFG_W-1:0] ring_size_r, ring_size_nxt;
  logic [CFG_W-1:0] prebuf_r, prebuf_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    ring_size_nxt = ring_size_r;
    prebuf_nxt    = prebuf_r;
    prdata        = '0;
    unique case (paddr[2])
      REG_RING_SIZE: begin
        if (wr_en) ring_size_nxt = pwdata[CFG_W-1:0];
        prdata = PDATA_W'(ring_size_r);
      end
      REG_PREBUF: begin
        if (wr_en) prebuf_nxt = pwdata[CFG_W-1:0];
        prdata = PDATA_W'(prebuf_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= CFG_W'(DEPTH);
      prebuf_r    <= '0;
    end else begin
      ring_size_r <= ring_size_nxt;
      prebuf_r    <= prebuf_nxt;
    end
  end

  assign cfg.ring_size       = ring_size_r;
  assign cfg.prebuffer_count = prebuf_r;

endmodule

// ===== rtl/core/pfr_ctrl.sv =====
// Request sequencer of the frame ring: accept, then present the result.
// Depends on pfr_pkg.
module pfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output pfr_pkg::ctl_cmd_t cmd
);
  import pfr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.exec  = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        busy      = 1'b1;
        out_valid = 1'b1;
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/pfr_dp.sv =====
// Datapath of the frame ring: descriptor memory, pointers, occupancy,
// gate flags and result registers. Depends on pfr_pkg.
module pfr_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  pfr_pkg::ctl_cmd_t  cmd,
  input  pfr_pkg::cfg_t      cfg,
  input  pfr_pkg::in_item_t  req,
  output pfr_pkg::out_item_t rsp
);
  import pfr_pkg::*;

  desc_t            mem [DEPTH];
  desc_t            rd_q;
  desc_t            wr_desc;
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic             stop_r, stop_nxt;
  logic             drain_r, drain_nxt;
  status_t          status_r, status_nxt;
  logic             hit_r, hit_nxt;
  logic             wr_en;
  logic             rd_en;
  logic [CNT_W-1:0] eff;
  logic [CNT_W:0]   occ_inc;
  logic [CNT_W-1:0] occ_dec;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                              input logic [CNT_W-1:0] sz);
    logic [CNT_W:0] n;
    n = (CNT_W + 1)'(p) + (CNT_W + 1)'(1);
    return (n >= (CNT_W + 1)'(sz)) ? '0 : PTR_W'(n);
  endfunction

  always_comb begin
    if (32'(cfg.ring_size) < 2) begin
      eff = CNT_W'(2);
    end else if (32'(cfg.ring_size) > DEPTH) begin
      eff = CNT_W'(DEPTH);
    end else begin
      eff = CNT_W'(cfg.ring_size);
    end
  end

  assign occ_inc = (CNT_W + 1)'(occ_r) + (CNT_W + 1)'(1);
  assign occ_dec = occ_r - CNT_W'(1);

  always_comb begin
    wr_desc.id   = req.stream_id;
    wr_desc.user = req.user_data;
    wr_desc.len  = req.frame_length;
    if (32'(req.frame_length) > MAX_LENGTH) wr_desc.len = LEN_W'(MAX_LENGTH);
  end

  always_comb begin
    wptr_nxt   = wptr_r;
    rptr_nxt   = rptr_r;
    occ_nxt    = occ_r;
    stop_nxt   = stop_r;
    drain_nxt  = drain_r;
    status_nxt = status_r;
    hit_nxt    = hit_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    if (cmd.exec) begin
      status_nxt = ST_OK;
      hit_nxt    = 1'b0;
      if (stop_r && req.req_type != REQ_RESTART) begin
        status_nxt = ST_STOPPED;
      end else begin
        unique case (req.req_type)
          REQ_ADD: begin
            wr_en = 1'b1;
            if (occ_inc >= (CNT_W + 1)'(eff)) begin
              wptr_nxt   = '0;
              rptr_nxt   = '0;
              occ_nxt    = '0;
              drain_nxt  = 1'b0;
              status_nxt = ST_OVERFLOW;
            end else begin
              wptr_nxt = advance(wptr_r, eff);
              occ_nxt  = CNT_W'(occ_inc);
            end
          end
          REQ_GET: begin
            if (!drain_r && 32'(occ_r) < 32'(cfg.prebuffer_count)) begin
              status_nxt = ST_PREBUF;
            end else if (occ_r == '0) begin
              drain_nxt  = 1'b0;
              status_nxt = ST_EMPTY;
            end else begin
              rd_en     = 1'b1;
              hit_nxt   = 1'b1;
              rptr_nxt  = advance(rptr_r, eff);
              occ_nxt   = occ_dec;
              drain_nxt = (occ_dec != '0);
            end
          end
          REQ_RESTART: begin
            wptr_nxt  = '0;
            rptr_nxt  = '0;
            occ_nxt   = '0;
            drain_nxt = 1'b0;
            stop_nxt  = 1'b0;
          end
          REQ_STOP: begin
            stop_nxt = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wptr_r] <= wr_desc;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= mem[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      occ_r   <= '0;
      stop_r  <= 1'b0;
      drain_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      occ_r   <= occ_nxt;
      stop_r  <= stop_nxt;
      drain_r <= drain_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  always_comb begin
    rsp.status        = status_r;
    rsp.out_stream_id = hit_r ? rd_q.id : '0;
    rsp.out_user_data = hit_r ? rd_q.user : '0;
    rsp.out_length    = hit_r ? rd_q.len : '0;
    rsp.fill_level    = CFG_W'(occ_r);
    if (!cmd.emit) rsp.status = ST_OK;
  end

endmodule

// ===== rtl/core/prebuffered_frame_ring.sv =====
// Prebuffered frame ring: descriptor ring with a prebuffer gate on gets.
// Latency: the result strobes on out_valid in the cycle after a request is taken.
// A new request is not taken while a result is presented; busy is high during the
// result cycle, set by the controller state. The receiver cannot stall.
// Reset clears pointers, occupancy and flags, sets ring_size 64 and
// prebuffer_count 0; descriptor memory is not cleared.
module prebuffered_frame_ring (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  pfr_pkg::in_item_t            in_req,
  output logic                         out_valid,
  output pfr_pkg::out_item_t           out_rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pfr_pkg::PADDR_W-1:0]  paddr,
  input  logic [pfr_pkg::PDATA_W-1:0]  pwdata,
  output logic [pfr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import pfr_pkg::*;

  cfg_t     cfg;
  ctl_cmd_t cmd;

  pfr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pfr_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .cfg   (cfg),
    .req   (in_req),
    .rsp   (out_rsp)
  );

  a_accept_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid)
    else $error("accepted item produced no result");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result repeated");

  a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status != ST_OK |->
      out_rsp.out_length == '0 && out_rsp.out_stream_id == '0 &&
      out_rsp.out_user_data == '0)
    else $error("frame fields set without a returned frame");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_rsp.fill_level) < DEPTH)
    else $error("fill level beyond ring depth");

endmodule
